// ===== rtl/most_overdue_task_picker_assert.svh =====
// assertion macros used by the scheduler datapath
// expects clk and rst_n in the scope where the macros are used
`ifndef MOST_OVERDUE_TASK_PICKER_ASSERT_SVH
`define MOST_OVERDUE_TASK_PICKER_ASSERT_SVH

// plain invariant, checked every clock outside reset
`define MOTP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define MOTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/motp_pkg.sv =====
// shared types and constants for the most overdue task picker
// no dependencies
package motp_pkg;

  localparam int TIME_W     = 32;
  localparam int IVAL_W     = 16;
  localparam int TASK_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int FAST_SLOTS = 4;

  localparam logic [IVAL_W-1:0] FAST_IVAL = 16'd50;
  localparam logic [IVAL_W-1:0] SLOW_IVAL = 16'd100;

  // command codes of an input word
  localparam logic CMD_PICK = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input word, clear scan
    logic step;    // fetch due time of next task
    logic commit;  // update task state, register the result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_need;  // incoming word is a pick and nothing is in flight
    logic scan_last;  // scan counter at the last task
  } dp_stat_t;

  function automatic logic [IVAL_W-1:0] default_interval(input int idx);
    default_interval = (idx < FAST_SLOTS) ? FAST_IVAL : SLOW_IVAL;
  endfunction

endpackage

// ===== rtl/most_overdue_task_picker.sv =====
// top level of the most overdue task picker: controller plus datapath
// depends on motp_pkg, motp_ctrl, motp_dp
//
// a pick word with nothing in flight scans one task per cycle, then passes the drain
// and commit states; the result strobe is registered from commit, and busy falls in that cycle;
// completions and ignored picks go from idle straight to commit
// the scan rate is set by the single read port into the last-run / interval tables
// results are strobed for one cycle; the receiver cannot stall
// synchronous active-low reset: tasks idle, last-run stamps zero, intervals 50/100 ms
module most_overdue_task_picker #(
  parameter int NUM_TASKS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input word: command and current time
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic [motp_pkg::TIME_W-1:0]      in_now_ms,
  // interval register writes, index i is task i
  input  logic                             cfg_we,
  input  logic [motp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [motp_pkg::IVAL_W-1:0]      cfg_data,
  // result word, valid for one cycle
  output logic                             out_valid,
  output logic                             out_picked,
  output logic [motp_pkg::TASK_IDX_W-1:0]  out_task_index,
  output logic                             out_busy_res
);

  // command and status between the sequencer and the datapath
  motp_pkg::ctl_cmd_t ctl;
  motp_pkg::dp_stat_t stat;

  // sequencer: idle, scan, drain of the compare stage, commit
  motp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // datapath: due time fetch, margin compare, in-flight bookkeeping
  motp_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_command     (in_command),
    .in_now_ms      (in_now_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_picked     (out_picked),
    .out_task_index (out_task_index),
    .out_busy_res   (out_busy_res)
  );

endmodule

// ===== rtl/motp_ctrl.sv =====
// sequencing state machine of the most overdue task picker
// depends on motp_pkg
module motp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  motp_pkg::dp_stat_t  stat,
  output motp_pkg::ctl_cmd_t  ctl,
  output logic                busy
);

  motp_pkg::state_t state_r;
  motp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= motp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    case (state_r)
      motp_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = stat.scan_need ? motp_pkg::ST_SCAN : motp_pkg::ST_COMMIT;
        end
      end
      motp_pkg::ST_SCAN: begin
        ctl.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = motp_pkg::ST_DRAIN;
        end
      end
      motp_pkg::ST_DRAIN: begin
        state_nxt = motp_pkg::ST_COMMIT;
      end
      motp_pkg::ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = motp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = motp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/motp_dp.sv =====
// datapath: task tables, due time scan, in-flight state and result register
// depends on motp_pkg and most_overdue_task_picker_assert.svh
module motp_dp #(
  parameter int NUM_TASKS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  motp_pkg::ctl_cmd_t                   ctl,
  output motp_pkg::dp_stat_t                   stat,
  input  logic                                 in_command,
  input  logic [motp_pkg::TIME_W-1:0]          in_now_ms,
  input  logic                                 cfg_we,
  input  logic [motp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [motp_pkg::IVAL_W-1:0]          cfg_data,
  output logic                                 out_valid,
  output logic                                 out_picked,
  output logic [motp_pkg::TASK_IDX_W-1:0]      out_task_index,
  output logic                                 out_busy_res
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TW    = motp_pkg::TIME_W;

  logic [TW-1:0]               last_run_r [NUM_TASKS];
  logic [motp_pkg::IVAL_W-1:0] ival_r     [NUM_TASKS];

  logic             in_flight_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] cnt_r;
  logic             found_r;
  logic             eval_v_r;

  logic [TW-1:0]    now_r;
  logic             cmd_r;
  logic [TW-1:0]    due_r;
  logic [IDX_W-1:0] eval_idx_r;
  logic [TW-1:0]    best_r;
  logic [IDX_W-1:0] best_idx_r;

  logic                              out_valid_r;
  logic                              out_picked_r;
  logic [motp_pkg::TASK_IDX_W-1:0]   out_task_index_r;
  logic                              out_busy_res_r;

  logic [TW:0]      diff;
  logic             take;
  logic             retire;
  logic             in_flight_nxt;
  logic [IDX_W-1:0] cur_nxt;

  assign stat.scan_need = (in_command == motp_pkg::CMD_PICK) && !in_flight_r;
  assign stat.scan_last = (cnt_r == IDX_W'(NUM_TASKS - 1));

  // margin of the fetched due time; top bit is the borrow (not yet due)
  assign diff = {1'b0, now_r} - {1'b0, due_r};
  assign take = eval_v_r && !diff[TW] && (diff[TW-1:0] > best_r);

  assign retire = (cmd_r == motp_pkg::CMD_DONE) && in_flight_r;

  always_comb begin
    in_flight_nxt = in_flight_r;
    cur_nxt       = cur_r;
    if (retire) begin
      in_flight_nxt = 1'b0;
      cur_nxt       = '0;
    end else if ((cmd_r == motp_pkg::CMD_PICK) && found_r && !in_flight_r) begin
      in_flight_nxt = 1'b1;
      cur_nxt       = best_idx_r;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        last_run_r[i] <= '0;
        ival_r[i]     <= motp_pkg::default_interval(i);
      end
      in_flight_r <= 1'b0;
      cur_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.commit;
      eval_v_r    <= ctl.step;
      if (cfg_we && (cfg_index < motp_pkg::CFG_IDX_W'(NUM_TASKS))) begin
        ival_r[cfg_index[IDX_W-1:0]] <= cfg_data;
      end
      if (ctl.load) begin
        cnt_r <= '0;
      end else if (ctl.step) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (ctl.load) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (ctl.commit) begin
        in_flight_r <= in_flight_nxt;
        cur_r       <= cur_nxt;
        if (retire) begin
          last_run_r[cur_r] <= now_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      now_r  <= in_now_ms;
      cmd_r  <= in_command;
      best_r <= '0;
    end else if (take) begin
      best_r     <= diff[TW-1:0];
      best_idx_r <= eval_idx_r;
    end
    if (ctl.step) begin
      due_r      <= last_run_r[cnt_r] + TW'(ival_r[cnt_r]);
      eval_idx_r <= cnt_r;
    end
    if (ctl.commit) begin
      out_picked_r     <= found_r;
      out_busy_res_r   <= in_flight_nxt;
      out_task_index_r <= in_flight_nxt ? motp_pkg::TASK_IDX_W'(cur_nxt) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_picked     = out_picked_r;
  assign out_task_index = out_task_index_r;
  assign out_busy_res   = out_busy_res_r;

`include "most_overdue_task_picker_assert.svh"

  `MOTP_ASSERT_IMP(a_pick_busy, out_valid_r && out_picked_r, out_busy_res_r, "picked but not busy")
  `MOTP_ASSERT_IMP(a_idle_index, !in_flight_r, cur_r == '0, "current index not cleared while idle")
  `MOTP_ASSERT_IMP(a_found_margin, found_r, best_r != '0, "candidate recorded with zero margin")

endmodule
